>>> rtl/core/ufsw_pkg.sv
`default_nettype none

package ufsw_pkg;

  // fixed field widths of the channels
  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int GRID_W     = 6;
  localparam int WIDX_W     = 10;
  localparam int CFG_IDX_W  = 1;
  // side after clamping, and cell numbers, sized for the largest grid supported
  localparam int SIDE_W     = 7;
  localparam int CELL_MAX_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic FUNC_WALL  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = 6'd8;

  typedef struct packed {
    logic             func;
    logic             horizontal;
    logic [ROW_W-1:0] wall_row;
    logic [COL_W-1:0] wall_col;
  } wall_item_t;

  typedef struct packed {
    logic              removed;
    logic [WIDX_W-1:0] wall_index;
    logic              bad_wall;
  } result_t;

  typedef struct packed {
    logic                  ok;
    logic [CELL_MAX_W-1:0] cell_a;
    logic [CELL_MAX_W-1:0] cell_b;
    logic [WIDX_W-1:0]     wall_index;
  } wall_info_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_REQ_A,
    ST_FIND_A,
    ST_FIND_B,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/ufsw_channels.sv
`default_nettype none

interface ufsw_wall_if import ufsw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic             horizontal;
  logic [ROW_W-1:0] wall_row;
  logic [COL_W-1:0] wall_col;

  modport source (output valid, func, horizontal, wall_row, wall_col, input ready);
  modport sink   (input valid, func, horizontal, wall_row, wall_col, output ready);
endinterface

interface ufsw_result_if import ufsw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              removed;
  logic [WIDX_W-1:0] wall_index;
  logic              bad_wall;

  modport source (output valid, removed, wall_index, bad_wall, input ready);
  modport sink   (input valid, removed, wall_index, bad_wall, output ready);
endinterface

interface ufsw_cfg_if import ufsw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GRID_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/union_find_spanning_wall_removal_unit.sv
`default_nettype none

// channel   dir  handshake     payload
// wall      in   valid/ready   func, horizontal, wall_row, wall_col
// result    out  valid/ready   removed, wall_index, bad_wall
// cfg       in   valid/ready   index (0 grid_rows, 1 grid_cols), data
//
// a wall item passes through the calc, request, find and response states; the
// finds walk the parent chain of each of the two cells a step at a time, set by
// the single read port of the parent memory; a bad wall skips the finds
// a clear sweeps the parent memory; the same sweep runs after reset before any item
// result register sits behind the engine: one item can be accepted while the
// previous result is still held by a stalled sink

module union_find_spanning_wall_removal_unit import ufsw_pkg::*; #(
  parameter int MAX_SIDE = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ufsw_wall_if.sink     wall,
  ufsw_result_if.source result,
  ufsw_cfg_if.sink      cfg
);

  logic [GRID_W-1:0] grid_rows;
  logic [GRID_W-1:0] grid_cols;
  wall_item_t        item_q;
  wall_info_t        info;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_RESET;
      grid_cols <= GRID_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GRID_ROWS: grid_rows <= cfg.data;
        REG_GRID_COLS: grid_cols <= cfg.data;
        default: ;
      endcase
    end
  end

  ufsw_wall_decode #(
    .MAX_SIDE (MAX_SIDE)
  ) u_decode (
    .item      (item_q),
    .grid_rows (grid_rows),
    .grid_cols (grid_cols),
    .info      (info)
  );

  ufsw_engine #(
    .MAX_SIDE (MAX_SIDE)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .wall   (wall),
    .result (result),
    .info   (info),
    .item_q (item_q)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (wall.valid && wall.ready) |=> !wall.ready)
    else $error("engine took a second item while busy");

  a_bad_not_removed: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.removed && result.bad_wall))
    else $error("bad wall reported as removed");

  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.bad_wall) |-> (result.wall_index == '0))
    else $error("bad wall carries a wall index");

endmodule

`default_nettype wire

>>> rtl/core/ufsw_ram.sv
`default_nettype none

module ufsw_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/ufsw_wall_decode.sv
`default_nettype none

module ufsw_wall_decode import ufsw_pkg::*; #(
  parameter int MAX_SIDE = 32
) (
  input  wire wall_item_t        item,
  input  wire logic [GRID_W-1:0] grid_rows,
  input  wire logic [GRID_W-1:0] grid_cols,
  output wall_info_t             info
);

  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

  logic [SIDE_W-1:0]     rows;
  logic [SIDE_W-1:0]     cols;
  logic [SIDE_W-1:0]     cols_m1;
  logic [SIDE_W-1:0]     r_ext;
  logic [SIDE_W-1:0]     c_ext;
  logic [CELL_MAX_W-1:0] a_num;
  logic [CELL_MAX_W-1:0] v_num;

  always_comb begin
    rows = ({1'b0, grid_rows} > SIDE_MAX) ? SIDE_MAX : {1'b0, grid_rows};
    cols = ({1'b0, grid_cols} > SIDE_MAX) ? SIDE_MAX : {1'b0, grid_cols};
    cols_m1 = cols - SIDE_W'(1);
    r_ext = SIDE_W'(item.wall_row);
    c_ext = SIDE_W'(item.wall_col);

    if (item.horizontal) begin
      info.ok = ((r_ext + SIDE_W'(1)) < rows) && (c_ext < cols);
    end else begin
      info.ok = (r_ext < rows) && ((c_ext + SIDE_W'(1)) < cols);
    end

    a_num = CELL_MAX_W'(CELL_MAX_W'(item.wall_row) * CELL_MAX_W'(cols))
          + CELL_MAX_W'(item.wall_col);
    // vertical walls number over cols-1 per row
    v_num = CELL_MAX_W'(CELL_MAX_W'(item.wall_row) * CELL_MAX_W'(cols_m1))
          + CELL_MAX_W'(item.wall_col);

    info.cell_a = a_num;
    if (item.horizontal) begin
      info.cell_b     = a_num + CELL_MAX_W'(cols);
      info.wall_index = a_num[WIDX_W-1:0];
    end else begin
      info.cell_b     = a_num + CELL_MAX_W'(1);
      info.wall_index = v_num[WIDX_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ufsw_engine.sv
`default_nettype none

module ufsw_engine import ufsw_pkg::*; #(
  parameter int MAX_SIDE = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  ufsw_wall_if.sink         wall,
  ufsw_result_if.source     result,
  input  wire wall_info_t   info,
  output wall_item_t        item_q
);

  localparam int NCELLS = MAX_SIDE * MAX_SIDE;
  localparam int CW     = $clog2(NCELLS);
  localparam logic [CW-1:0] LAST_CELL = CW'(NCELLS - 1);

  state_t state, state_next;

  logic [CW-1:0] clr_addr;
  logic          clr_reply;
  logic          res_valid;
  result_t       res_q;
  result_t       pend;
  wall_info_t    info_q;
  logic [CW-1:0] node;
  logic [CW-1:0] child;
  logic          have_child;
  logic [CW-1:0] root_a;

  logic          we;
  logic [CW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [CW-1:0] raddr;
  logic [CW-1:0] rdata;
  logic          at_root;
  logic          accept;
  logic          res_load;

  ufsw_ram #(
    .WIDTH (CW),
    .DEPTH (NCELLS)
  ) u_parent (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign at_root  = (rdata == node);
  assign accept   = wall.valid && wall.ready;
  assign res_load = (state == ST_RESP) && (!res_valid || result.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_CELL) begin
          state_next = clr_reply ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (wall.valid) begin
          state_next = (wall.func == FUNC_CLEAR) ? ST_CLEAR : ST_CALC;
        end
      end
      ST_CALC:   state_next = info.ok ? ST_REQ_A : ST_RESP;
      ST_REQ_A:  state_next = ST_FIND_A;
      ST_FIND_A: if (at_root) state_next = ST_FIND_B;
      ST_FIND_B: if (at_root) state_next = ST_RESP;
      ST_RESP:   if (!res_valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory control: each find step reads the parent of the next node and
  // hangs the previous node on its grandparent
  always_comb begin
    we         = 1'b0;
    waddr      = clr_addr;
    wdata      = clr_addr;
    raddr      = rdata;
    wall.ready = 1'b0;
    case (state)
      ST_CLEAR: we = 1'b1;
      ST_IDLE:  wall.ready = 1'b1;
      ST_REQ_A: raddr = CW'(info_q.cell_a);
      ST_FIND_A: begin
        if (at_root) begin
          raddr = CW'(info_q.cell_b);
        end else begin
          we    = have_child;
          waddr = child;
          wdata = rdata;
        end
      end
      ST_FIND_B: begin
        if (at_root) begin
          we    = (root_a != node);
          waddr = root_a;
          wdata = node;
        end else begin
          we    = have_child;
          waddr = child;
          wdata = rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + CW'(1);
      end
      if (accept) begin
        clr_addr  <= '0;
        clr_reply <= (wall.func == FUNC_CLEAR);
      end
      if (res_load) begin
        res_valid <= 1'b1;
        clr_reply <= 1'b0;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.func       <= wall.func;
      item_q.horizontal <= wall.horizontal;
      item_q.wall_row   <= wall.wall_row;
      item_q.wall_col   <= wall.wall_col;
      pend              <= '0;
    end
    if (state == ST_CALC) begin
      info_q <= info;
      if (!info.ok) begin
        pend.bad_wall <= 1'b1;
      end
    end
    if (state == ST_REQ_A) begin
      node       <= CW'(info_q.cell_a);
      have_child <= 1'b0;
    end
    if ((state == ST_FIND_A) || (state == ST_FIND_B)) begin
      if (at_root) begin
        node       <= CW'(info_q.cell_b);
        have_child <= 1'b0;
        if (state == ST_FIND_A) begin
          root_a <= node;
        end else begin
          pend.removed    <= (root_a != node);
          pend.wall_index <= info_q.wall_index;
        end
      end else begin
        child      <= node;
        node       <= rdata;
        have_child <= 1'b1;
      end
    end
    if (res_load) begin
      res_q <= pend;
    end
  end

  assign result.valid      = res_valid;
  assign result.removed    = res_q.removed;
  assign result.wall_index = res_q.wall_index;
  assign result.bad_wall   = res_q.bad_wall;

endmodule

`default_nettype wire
